@@ src/assert_macros.svh @@
// Shared assertion macros; every property is clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant that must hold at every clock edge out of reset.
`define OLADS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define OLADS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OLADS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/olads_pkg.sv @@
package olads_pkg;

	localparam int CAPACITY = 16;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int FP_W     = 4;
	localparam int LEN_W    = 5;

	// index of one cell, and a count that can reach CAPACITY
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// common width for comparing a list index with the fill count
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND   = 2'd0,
		FUNC_DELETE   = 2'd1,
		FUNC_SEARCH   = 2'd2,
		FUNC_RESERVED = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_MISS  = 2'd3
	} status_t;

	// per-cell command from the list controller
	typedef struct packed {
		logic write;       // take the incoming value (append at tail)
		logic shift;       // take the right neighbor's entry (delete)
		logic load_match;  // capture entry == value (search start)
		logic shift_match; // take the right neighbor's match flag (search scan)
	} cell_ctrl_t;

endpackage

@@ src/ordered_list_append_delete_search.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | func, value, position
// out     | output    | out_valid / out_ready| status, found_position, length
//
// Append, delete and reserved operations finish at the accepting edge: the cell
// row updates and the result is registered at that edge.
// Search is a scan: match flags are captured in every cell
// at once, then shifted one cell per cycle toward the head while a counter
// walks the list; the first flag to reach cell 0 gives the position.
// One transaction is in flight at a time; in_ready is high when the scan
// is idle and the output register is empty or being drained.
// arst_n empties the list and drops any pending result.
module ordered_list_append_delete_search (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [olads_pkg::FUNC_W-1:0]           func,
	input  logic signed [olads_pkg::VALUE_W-1:0]   value,
	input  logic [olads_pkg::POS_W-1:0]            position,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [olads_pkg::STATUS_W-1:0]         status,
	output logic [olads_pkg::FP_W-1:0]             found_position,
	output logic [olads_pkg::LEN_W-1:0]            length
);
	import olads_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [IDX_W-1:0] found_q;

	logic                      in_fire;
	logic                      is_full;
	logic                      pos_ok;
	logic                      do_append;
	logic                      do_delete;
	logic                      do_search;
	logic                      scan_end;
	logic                      head_match;
	logic                      scan_step;
	status_t                   status_d;

	cell_ctrl_t                cell_ctrl [CAPACITY];
	logic signed [VALUE_W-1:0] entry_w   [CAPACITY];
	logic                      match_w   [CAPACITY];

	// Accept only when no scan is running and the result slot frees up.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign pos_ok    = (CMP_W'(position) < CMP_W'(count_q));
	assign do_append = in_fire && (func == FUNC_APPEND) && !is_full;
	assign do_delete = in_fire && (func == FUNC_DELETE) && pos_ok;
	assign do_search = in_fire && (func == FUNC_SEARCH);

	// Scan ends on a miss once every live entry has passed the head cell.
	assign head_match = match_w[0];
	assign scan_end   = (scan_cnt_q == count_q);
	assign scan_step  = (state_q == ST_SCAN) && !scan_end && !head_match;

	// Status for operations that finish at the accepting edge.
	always_comb begin
		case (func)
			FUNC_APPEND: status_d = is_full ? STATUS_FULL : STATUS_OK;
			FUNC_DELETE: status_d = pos_ok ? STATUS_OK : STATUS_RANGE;
			default:     status_d = STATUS_OK;
		endcase
	end

	// Cell row: each cell gets its command and its right neighbor's data.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctrl[i].write       = do_append && (CNT_W'(i) == count_q);
		assign cell_ctrl[i].shift       = do_delete && (CMP_W'(i) >= CMP_W'(position));
		assign cell_ctrl[i].load_match  = do_search;
		assign cell_ctrl[i].shift_match = scan_step;

		if (i == CAPACITY - 1) begin : g_tail
			olads_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.value      (value),
				.next_entry ('0),
				.next_match (1'b0),
				.entry      (entry_w[i]),
				.match      (match_w[i])
			);
		end else begin : g_body
			olads_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl[i]),
				.value      (value),
				.next_entry (entry_w[i+1]),
				.next_match (match_w[i+1]),
				.entry      (entry_w[i]),
				.match      (match_w[i])
			);
		end
	end

	// Control: state, fill count, scan counter, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// fill count: grow on append, shrink on delete
			if (do_append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_delete) begin
				count_q <= count_q - CNT_W'(1);
			end

			case (state_q)
				ST_IDLE: begin
					if (do_search) begin
						state_q    <= ST_SCAN;
						scan_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_end || head_match) begin
						state_q <= ST_IDLE;
					end else begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// raise on a finished transaction, drop once taken
			if (in_fire && (func != FUNC_SEARCH)) begin
				out_valid_q <= 1'b1;
			end else if ((state_q == ST_SCAN) && (scan_end || head_match)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; written only when the slot is free or draining.
	always_ff @(posedge clk) begin
		if (in_fire && (func != FUNC_SEARCH)) begin
			status_q <= status_d;
			found_q  <= '0;
		end else if ((state_q == ST_SCAN) && scan_end) begin
			status_q <= STATUS_MISS;
			found_q  <= '0;
		end else if ((state_q == ST_SCAN) && head_match) begin
			status_q <= STATUS_OK;
			found_q  <= scan_cnt_q[IDX_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = FP_W'(found_q);
	// count only moves at an accept, which needs the result slot free,
	// so it holds steady while a result waits
	assign length         = LEN_W'(count_q);

	`OLADS_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
	`OLADS_ASSERT_NOW(a_scan_no_result, state_q == ST_SCAN, !out_valid_q,
		"result pending during a scan")
	`OLADS_ASSERT_NOW(a_scan_in_list, state_q == ST_SCAN, scan_cnt_q <= count_q,
		"scan walked past the list end")
	`OLADS_ASSERT_NEXT(a_append_grows, do_append, count_q == $past(count_q) + CNT_W'(1),
		"append did not grow the list")

endmodule

@@ src/olads_cell.sv @@
module olads_cell (
	input  logic                                clk,
	input  olads_pkg::cell_ctrl_t               ctrl,
	input  logic signed [olads_pkg::VALUE_W-1:0] value,
	input  logic signed [olads_pkg::VALUE_W-1:0] next_entry,
	input  logic                                next_match,
	output logic signed [olads_pkg::VALUE_W-1:0] entry,
	output logic                                match
);
	import olads_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;
	logic                      match_q;

	// hold the entry; overwrite on append, pull from the neighbor on delete
	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			entry_q <= value;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	// match flag: compare in place, then march toward the head of the list
	always_ff @(posedge clk) begin
		if (ctrl.load_match) begin
			match_q <= (entry_q == value);
		end else if (ctrl.shift_match) begin
			match_q <= next_match;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	import olads_pkg::*;

	// Expected outcome of one list operation, in the block's output widths.
	typedef struct packed {
		status_t               status;
		logic [FP_W-1:0]       found_position;
		logic [LEN_W-1:0]      length;
	} list_outcome_t;

	// Scoreboard: a shadow copy of the ordered list and the queue of
	// outcomes that the block still owes.
	class list_scoreboard;
		logic signed [VALUE_W-1:0] entries [CAPACITY];
		int unsigned               fill;
		list_outcome_t             owed [$];
		int unsigned               errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		// Apply an accepted operation to the shadow list; queue its outcome.
		function void note_input(func_t f, logic signed [VALUE_W-1:0] v,
				logic [POS_W-1:0] p);
			list_outcome_t r;
			r.status = STATUS_OK;
			r.found_position = '0;
			case (f)
				FUNC_APPEND: begin
					if (fill >= CAPACITY) begin
						r.status = STATUS_FULL;
					end else begin
						entries[fill] = v;
						fill++;
					end
				end
				FUNC_DELETE: begin
					if (p >= fill) begin
						r.status = STATUS_RANGE;
					end else begin
						for (int i = p; i + 1 < fill; i++)
							entries[i] = entries[i + 1];
						fill--;
					end
				end
				FUNC_SEARCH: begin
					r.status = STATUS_MISS;
					for (int i = 0; i < fill; i++) begin
						if (entries[i] == v) begin
							r.status = STATUS_OK;
							r.found_position = FP_W'(i);
							break;
						end
					end
				end
				default: ;
			endcase
			r.length = LEN_W'(fill);
			owed.push_back(r);
		endfunction

		// Compare one accepted result with the oldest owed outcome.
		function void check_result(logic [STATUS_W-1:0] st, logic [FP_W-1:0] fp,
				logic [LEN_W-1:0] len);
			list_outcome_t e;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing owed: status %0d pos %0d length %0d",
					$time, st, fp, len);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (fp !== e.found_position) begin
				$display("%0t: found_position expected %0d actual %0d",
					$time, e.found_position, fp);
				errors++;
			end
			if (len !== e.length) begin
				$display("%0t: length expected %0d actual %0d", $time, e.length, len);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [FUNC_W-1:0]          func;
	logic signed [VALUE_W-1:0]  value;
	logic [POS_W-1:0]           position;
	logic                       out_valid;
	logic                       out_ready;
	logic [STATUS_W-1:0]        status;
	logic [FP_W-1:0]            found_position;
	logic [LEN_W-1:0]           length;

	list_scoreboard ledger = new();

	// Idling switch shared by both sides, and the long receiver hold-off
	// request: the sender bumps choke_asked, the sink answers it once.
	bit          idle_on = 1'b1;
	int unsigned choke_asked = 0;
	int unsigned choke_taken = 0;

	ordered_list_append_delete_search i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.value          (value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found_position (found_position),
		.length         (length)
	);

	always #6 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (every search scanning a
	// full list, every gap and stall at its longest, plus the long hold-off).
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one operation and hold it until the block takes it. Now and then insert a
	// random gap first while idling is on. Called right after a rising edge.
	task automatic offer_op(func_t f, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// the transaction went through at this edge: predict its outcome now
		ledger.note_input(f, v, p);
	endtask

	// Result sink: check every accepted transaction, then decide whether to
	// stall the next cycle. Short random stalls while idling is on; one long
	// hold-off on request so the block backs up and drops in_ready.
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				ledger.check_result(status, found_position, length);
			if (hold != 0) begin
				hold--;
			end else if (choke_taken != choke_asked) begin
				choke_taken = choke_asked;
				hold = 250;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 8);
			end
			out_ready <= (hold == 0);
		end
	end

	initial begin : stimulus
		func_t                     f;
		logic signed [VALUE_W-1:0] v;
		logic [POS_W-1:0]          p;
		bit                        growing;
		int unsigned               pick;

		// Hold every input at a known value while reset is low.
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		func     <= FUNC_APPEND;
		value    <= '0;
		position <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-list corner cases first.
		offer_op(FUNC_SEARCH, 32'sd7, 4'd0);      // miss on an empty list
		offer_op(FUNC_DELETE, 32'sd0, 4'd0);      // delete with nothing stored
		offer_op(FUNC_RESERVED, -32'sd1, 4'd15);  // reserved code changes nothing

		// Fill to capacity with the value extremes and a duplicated value.
		for (int i = 0; i < CAPACITY; i++) begin
			case (i)
				0:       v = 32'sh8000_0000;
				1:       v = 32'sh7FFF_FFFF;
				2:       v = 32'sd0;
				3:       v = -32'sd1;
				7, 9:    v = 32'sd77;
				15:      v = 32'sh5A5A_A5A5;
				default: v = 32'sd100 + i;
			endcase
			offer_op(FUNC_APPEND, v, POS_W'(i));
		end
		offer_op(FUNC_APPEND, 32'sd123, 4'd0);           // append to a full list
		offer_op(FUNC_SEARCH, 32'sd77, 4'd0);            // first of two matches
		offer_op(FUNC_SEARCH, 32'sh5A5A_A5A5, 4'd3);     // match in the last slot
		offer_op(FUNC_DELETE, 32'sd0, 4'd15);            // drop the tail of a full list
		offer_op(FUNC_DELETE, 32'sd0, 4'd0);             // drop the head, shift all
		offer_op(FUNC_DELETE, 32'sd0, 4'd14);            // index just past the end
		offer_op(FUNC_SEARCH, 32'sh5A5A_A5A5, 4'd0);     // value deleted: miss

		// Random part: sweep the fill level up and down so that both ends of
		// the list are visited often; searches mostly hit stored values.
		growing = 1'b0;
		for (int k = 0; k < 850; k++) begin
			idle_on = (k < 700) && ((k / 100) % 3 != 1);
			if (k == 300)
				choke_asked++;
			if (ledger.fill == CAPACITY && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			else if (ledger.fill == 0 || $urandom_range(0, 39) == 0)
				growing = ~growing;

			pick = $urandom_range(0, 99);
			if (pick < 5)
				f = FUNC_RESERVED;
			else if (pick < 35)
				f = FUNC_SEARCH;
			else if (growing)
				f = (pick < 82) ? FUNC_APPEND : FUNC_DELETE;
			else
				f = (pick < 82) ? FUNC_DELETE : FUNC_APPEND;

			v = $urandom;
			p = POS_W'($urandom_range(0, 15));
			case (f)
				FUNC_APPEND: begin
					// narrow pool now and then, so duplicates show up
					if ($urandom_range(0, 9) < 4)
						v = $signed($urandom_range(0, 6)) - 3;
				end
				FUNC_DELETE: begin
					if (ledger.fill != 0 && $urandom_range(0, 9) < 8)
						p = POS_W'($urandom_range(0, ledger.fill - 1));
				end
				FUNC_SEARCH: begin
					if (ledger.fill != 0 && $urandom_range(0, 9) < 6)
						v = ledger.entries[$urandom_range(0, ledger.fill - 1)];
				end
				default: ;
			endcase
			offer_op(f, v, p);
		end
		in_valid <= 1'b0;

		// Drain: wait for every owed outcome, then keep watching a while longer to
		// catch any stray result.
		while (ledger.owed.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (ledger.errors == 0 && ledger.owed.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
